FILE: sv/ipv4p_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the dotted-decimal IPv4 address parser.
package ipv4p_pkg;

	localparam int unsigned OCTET_COUNT = 4;
	localparam int unsigned INDEX_W     = 2;

	localparam logic [7:0] CHAR_NUL  = 8'h00;
	localparam logic [7:0] CHAR_DOT  = 8'h2E;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(OCTET_COUNT - 1);
	localparam logic [11:0]        OCTET_MAX  = 12'd255;
	localparam logic [1:0]         DIGITS_MAX = 2'd3;

	typedef struct packed {
		logic [31:0] address;
		logic        status;
	} result_t;

endpackage

FILE: sv/ipv4p_char_if.sv
`timescale 1ns / 1ps
// Character channel: one text byte per transaction.
interface ipv4p_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;

	modport source (output valid, output text_char, input ready);
	modport sink   (input valid, input text_char, output ready);
endinterface

FILE: sv/ipv4p_result_if.sv
`timescale 1ns / 1ps
// Result channel: one parsed address and its status per transaction.
interface ipv4p_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] address;
	logic        status;

	modport source (output valid, output address, output status, input ready);
	modport sink   (input valid, input address, input status, output ready);
endinterface

FILE: sv/ipv4p_parse_core.sv
`timescale 1ns / 1ps
// Parser state and per-character update; gives the result for a NUL character.
module ipv4p_parse_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       ch,
	output logic             is_end,
	output ipv4p_pkg::result_t res
);
	import ipv4p_pkg::*;

	logic [INDEX_W-1:0] octet_index_q, octet_index_d;
	logic [7:0]         acc_q, acc_d;
	logic [1:0]         digit_count_q, digit_count_d;
	logic               leading_zero_q, leading_zero_d;
	logic               error_q, error_d;
	logic [23:0]        upper_q, upper_d;

	logic        is_digit;
	logic        is_dot;
	logic [3:0]  digit;
	logic [11:0] next_val;
	logic        digit_fault;
	logic        bad;
	logic [7:0]  ch_off;

	always_comb begin
		ch_off   = ch - CHAR_ZERO;
		digit    = ch_off[3:0];
		is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
		is_dot   = (ch == CHAR_DOT);
		is_end   = (ch == CHAR_NUL);
		// acc * 10 as two shifted copies.
		next_val = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {8'h00, digit};
		digit_fault = (digit_count_q == DIGITS_MAX) ||
			((digit_count_q != 2'd0) && leading_zero_q) || (next_val > OCTET_MAX);
	end

	always_comb begin
		octet_index_d  = octet_index_q;
		acc_d          = acc_q;
		digit_count_d  = digit_count_q;
		leading_zero_d = leading_zero_q;
		error_d        = error_q;
		upper_d        = upper_q;
		if (step) begin
			if (is_end) begin
				octet_index_d  = '0;
				acc_d          = '0;
				digit_count_d  = '0;
				leading_zero_d = 1'b0;
				error_d        = 1'b0;
				upper_d        = '0;
			end else if (!error_q) begin
				if (is_digit) begin
					if (digit_fault) begin
						error_d = 1'b1;
					end else begin
						if ((digit_count_q == 2'd0) && (digit == 4'd0)) begin
							leading_zero_d = 1'b1;
						end
						acc_d         = next_val[7:0];
						digit_count_d = digit_count_q + 2'd1;
					end
				end else if (is_dot) begin
					if ((digit_count_q == 2'd0) || (octet_index_q == LAST_INDEX)) begin
						error_d = 1'b1;
					end else begin
						upper_d        = {upper_q[15:0], acc_q};
						octet_index_d  = octet_index_q + INDEX_W'(1);
						acc_d          = '0;
						digit_count_d  = '0;
						leading_zero_d = 1'b0;
					end
				end else begin
					error_d = 1'b1;
				end
			end
		end
	end

	always_comb begin
		bad         = error_q || (digit_count_q == 2'd0) || (octet_index_q != LAST_INDEX);
		res.status  = bad;
		res.address = bad ? 32'd0 : {upper_q, acc_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octet_index_q  <= '0;
			acc_q          <= '0;
			digit_count_q  <= '0;
			leading_zero_q <= 1'b0;
			error_q        <= 1'b0;
			upper_q        <= '0;
		end else begin
			octet_index_q  <= octet_index_d;
			acc_q          <= acc_d;
			digit_count_q  <= digit_count_d;
			leading_zero_q <= leading_zero_d;
			error_q        <= error_d;
			upper_q        <= upper_d;
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && is_end) |=> (octet_index_q == '0 && digit_count_q == 2'd0 && !error_q))
		else $error("parser state not cleared after end of address");

	a_error_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(error_q && !(step && is_end)) |=> error_q)
		else $error("latched error dropped before end of address");

	a_leading_zero_single: assert property (@(posedge clk) disable iff (!arst_n)
		leading_zero_q |-> (digit_count_q == 2'd1 && acc_q == 8'd0))
		else $error("leading zero flag with more than one digit");

	a_empty_octet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(digit_count_q == 2'd0) |-> (acc_q == 8'd0 && !leading_zero_q))
		else $error("octet value present with no digits");

endmodule

FILE: sv/ipv4_dotted_quad_parser_top.sv
`timescale 1ns / 1ps
// Top level of the strict dotted-decimal IPv4 address parser.
// The block takes one text character per transaction and sustains one
// character per cycle. Each character is held in an input register, where the
// parser state is updated; a NUL character also loads the result register,
// which presents the result. Other characters give no result. The text must be
// four decimal octets of one to three digits, each at most 255 with no
// leading zero, joined by three dots; anything else gives status 1 with
// address zero. After every NUL the parser starts over.
// A stalled result output holds back the input only while a NUL character
// waits for the result register to free up.
module ipv4_dotted_quad_parser_top (
	input  logic            clk,
	input  logic            arst_n,
	ipv4p_char_if.sink      text,
	ipv4p_result_if.source  result
);
	import ipv4p_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       out_valid_q;
	result_t    out_res_q;

	logic    out_free;
	logic    advance;
	logic    is_end;
	result_t res;

	ipv4p_parse_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.ch     (char_s1),
		.is_end (is_end),
		.res    (res)
	);

	always_comb begin
		out_free   = !out_valid_q || result.ready;
		// Only a NUL needs room in the result register.
		advance    = valid_s1 && (!is_end || out_free);
		text.ready = !valid_s1 || advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			char_s1 <= text.text_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && is_end;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_end) begin
			out_res_q <= res;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.address = out_res_q.address;
	assign result.status  = out_res_q.status;

endmodule

FILE: dv/ipv4p_parse_checker.sv
`timescale 1ns / 1ps
// Checker for the IPv4 address parser: predicts each result and compares it.
module ipv4p_parse_checker (
	input  logic        clk,
	input  logic        arst_n,
	ipv4p_char_if       text_mon,
	ipv4p_result_if     result_mon,
	output int unsigned fail_count,
	output int unsigned outstanding
);
	import ipv4p_pkg::*;

	logic [INDEX_W-1:0] dots_seen;
	logic [7:0]         octet_val;
	logic [1:0]         digits;
	logic               first_zero;
	logic               faulted;
	logic [23:0]        done_octets;
	result_t            parsed_q[$];

	task automatic clear_parser();
		dots_seen   = '0;
		octet_val   = '0;
		digits      = '0;
		first_zero  = 1'b0;
		faulted     = 1'b0;
		done_octets = '0;
	endtask

	task automatic parse_char(input logic [7:0] c);
		logic [11:0] next_val;
		result_t     res;
		if (c == CHAR_NUL) begin
			if (faulted || digits == 2'd0 || dots_seen != LAST_INDEX) begin
				res.address = '0;
				res.status  = 1'b1;
			end else begin
				res.address = {done_octets, octet_val};
				res.status  = 1'b0;
			end
			parsed_q.push_back(res);
			clear_parser();
		end else if (!faulted) begin
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				next_val = 12'(octet_val) * 12'd10 + 12'(c - CHAR_ZERO);
				if (digits == DIGITS_MAX || (digits != 2'd0 && first_zero) ||
				    next_val > OCTET_MAX) begin
					faulted = 1'b1;
				end else begin
					if (digits == 2'd0 && c == CHAR_ZERO)
						first_zero = 1'b1;
					octet_val = next_val[7:0];
					digits    = digits + 2'd1;
				end
			end else if (c == CHAR_DOT) begin
				if (digits == 2'd0 || dots_seen == LAST_INDEX) begin
					faulted = 1'b1;
				end else begin
					done_octets = {done_octets[15:0], octet_val};
					dots_seen   = dots_seen + INDEX_W'(1);
					octet_val   = '0;
					digits      = '0;
					first_zero  = 1'b0;
				end
			end else begin
				faulted = 1'b1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			clear_parser();
			parsed_q.delete();
			fail_count  = 0;
			outstanding = 0;
		end else begin
			// A result comes out only after its NUL has been accepted, so predicting
			// first never hides a result.
			if (text_mon.valid && text_mon.ready)
				parse_char(text_mon.text_char);
			if (result_mon.valid && result_mon.ready) begin
				if (parsed_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, got address %h status %0d",
						$time, result_mon.address, result_mon.status);
					fail_count++;
				end else begin
					want = parsed_q.pop_front();
					if (result_mon.address !== want.address) begin
						$display("%0t: address mismatch, expected %h, got %h",
							$time, want.address, result_mon.address);
						fail_count++;
					end
					if (result_mon.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.status, result_mon.status);
						fail_count++;
					end
				end
			end
			outstanding = parsed_q.size();
		end
	end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the IPv4 address parser: stimulus, back pressure and verdict.
module tb_top;
	import ipv4p_pkg::*;

	localparam int unsigned CHAR_TARGET = 1400;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int          BOUNDARY_OCTETS [10] = '{0, 9, 10, 99, 100, 199, 200, 249, 250, 255};

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned chars_sent = 0;
	int unsigned cycle_count = 0;
	logic [7:0]  text_bytes[$];

	ipv4p_char_if   text_if();
	ipv4p_result_if result_if();

	ipv4_dotted_quad_parser_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.result (result_if)
	);

	ipv4p_parse_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_mon    (text_if),
		.result_mon  (result_if),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int pick_octet();
		if ($urandom_range(0, 9) < 3)
			return BOUNDARY_OCTETS[$urandom_range(0, 9)];
		return $urandom_range(0, 255);
	endfunction

	task automatic append_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_bytes.push_back(s[i]);
	endtask

	// Four octets joined by dots; one octet may be forced to a given value.
	task automatic build_quad(input int bad_idx, input int bad_val);
		for (int i = 0; i < 4; i++) begin
			if (i != 0)
				text_bytes.push_back(CHAR_DOT);
			append_str($sformatf("%0d", (i == bad_idx) ? bad_val : pick_octet()));
		end
	endtask

	task automatic build_malformed();
		int unsigned pos;
		build_quad(-1, 0);
		case ($urandom_range(0, 8))
			0: begin
				pos = $urandom_range(0, text_bytes.size());
				text_bytes.insert(pos, 8'($urandom_range(1, 255)));
			end
			1: text_bytes.delete($urandom_range(0, text_bytes.size() - 1));
			2: text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom_range(1, 255));
			3: text_bytes.push_front(CHAR_ZERO);
			4: begin
				text_bytes.push_back(CHAR_DOT);
				append_str($sformatf("%0d", pick_octet()));
			end
			5: begin
				while (text_bytes.size() > 0 && text_bytes[$] != CHAR_DOT)
					void'(text_bytes.pop_back());
				void'(text_bytes.pop_back());
			end
			6: begin
				text_bytes.delete();
				build_quad($urandom_range(0, 3), $urandom_range(256, 999));
			end
			7: begin
				text_bytes.delete();
				build_quad($urandom_range(0, 3), $urandom_range(1000, 9999));
			end
			default: begin
				// A dot at either end or doubled in the middle leaves an empty octet; one inside a number adds an octet.
				pos = $urandom_range(0, text_bytes.size());
				text_bytes.insert(pos, CHAR_DOT);
			end
		endcase
	endtask

	task automatic send_char(input logic [7:0] c, input bit no_gaps);
		int unsigned idle;
		idle = no_gaps ? 0 : gap_len();
		if (idle != 0) begin
			text_if.valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		text_if.valid     <= 1'b1;
		text_if.text_char <= c;
		// Everything changes on the rising edge, so ready seen at the falling edge holds.
		do @(negedge clk); while (!text_if.ready);
		@(posedge clk);
		chars_sent++;
	endtask

	task automatic send_text(input bit no_gaps);
		foreach (text_bytes[i])
			send_char(text_bytes[i], no_gaps);
		send_char(CHAR_NUL, no_gaps);
		text_bytes.delete();
	endtask

	task automatic wait_drained();
		text_if.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		result_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			int unsigned stall;
			stall = gap_len();
			if (stall != 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6))
				@(posedge clk);
		end
	end

	initial begin
		static string directed [] = '{
			"0.0.0.0", "255.255.255.255", "192.168.1.10", "9.99.199.249", "",
			"256.1.1.1", "1.1.1.260", "01.2.3.4", "1.2.3.00", "1234.5.6.7",
			".1.2.3", "1..2.3", "1.2.3.", "1.2.3.4.", "1.2.3.4.5", "1.2.3",
			"a.2.3.4", "1.2.3.4 ", "300.x.1.2"
		};
		int unsigned kind;
		bit          halfway_drained;
		text_if.valid     <= 1'b0;
		text_if.text_char <= CHAR_NUL;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			append_str(directed[i]);
			send_text(i % 2 == 0);
		end
		wait_drained();

		halfway_drained = 1'b0;
		while (chars_sent < CHAR_TARGET) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				build_quad(-1, 0);
			end else if (kind < 9) begin
				build_malformed();
			end else begin
				repeat ($urandom_range(0, 10))
					text_bytes.push_back(8'($urandom_range(1, 255)));
			end
			send_text($urandom_range(0, 3) == 0);
			if (!halfway_drained && chars_sent > CHAR_TARGET / 2) begin
				wait_drained();
				halfway_drained = 1'b1;
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
